/* src/vaa_pkg.sv */
package vaa_pkg;

    localparam int MAX_VOICES = 8;
    localparam int VOICE_W    = $clog2(MAX_VOICES);
    localparam int COUNT_W    = $clog2(MAX_VOICES + 1);

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [17:0] DECAY_EPS   = 18'd66;
    localparam logic [16:0] RELEASE_EPS = 17'd33;
    localparam logic [7:0]  NOTE_FREE   = 8'hFF;

    // envelope stages
    localparam logic [2:0] STG_IDLE = 3'd0;
    localparam logic [2:0] STG_ATK  = 3'd1;
    localparam logic [2:0] STG_DEC  = 3'd2;
    localparam logic [2:0] STG_SUS  = 3'd3;
    localparam logic [2:0] STG_REL  = 3'd4;

    // request kinds
    localparam logic [1:0] REQ_ON   = 2'd0;
    localparam logic [1:0] REQ_OFF  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // register indexes
    localparam logic [2:0] REG_VOICES  = 3'd0;
    localparam logic [2:0] REG_ATTACK  = 3'd1;
    localparam logic [2:0] REG_DECAY   = 3'd2;
    localparam logic [2:0] REG_SUSTAIN = 3'd3;
    localparam logic [2:0] REG_RELEASE = 3'd4;

    typedef struct packed {
        logic [16:0] atk_step;
        logic [15:0] dec_coef;
        logic [16:0] sus_level;   // already clipped to one
        logic [15:0] rel_coef;
    } env_cfg_t;

    typedef struct packed {
        logic [16:0] level;
        logic [2:0]  stage;
        logic        freed;
    } env_res_t;

endpackage

/* src/vaa_env_unit.sv */
module vaa_env_unit
(
    input  logic               clk,
    input  logic               mul_load,
    input  vaa_pkg::env_cfg_t  cfg,
    input  logic [2:0]         stage_in,
    input  logic [16:0]        level_in,
    output vaa_pkg::env_res_t  res
);

    logic [32:0] prod_reg;
    logic [32:0] prod_next;
    logic        above_reg;
    logic        above_next;
    logic [16:0] mag;
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [33:0] rounded;
    logic [16:0] delta;
    logic [17:0] atk_sum;

    // product step: distance and product, registered on mul_load
    always_comb
    begin
        above_next = (level_in >= cfg.sus_level);
        mag        = above_next ? (level_in - cfg.sus_level) : (cfg.sus_level - level_in);
        if (stage_in == vaa_pkg::STG_REL)
        begin
            mul_a = level_in;
            mul_b = cfg.rel_coef;
        end
        else
        begin
            mul_a = mag;
            mul_b = cfg.dec_coef;
        end
        prod_next = 33'(mul_a) * 33'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            prod_reg  <= prod_next;
            above_reg <= above_next;
        end
    end

    // update step: round up the registered product and apply
    always_comb
    begin
        rounded   = {1'b0, prod_reg} + 34'd65535;
        delta     = {1'b0, rounded[31:16]};
        atk_sum   = {1'b0, level_in} + {1'b0, cfg.atk_step};
        res.level = level_in;
        res.stage = stage_in;
        res.freed = 1'b0;
        unique case (stage_in)
            vaa_pkg::STG_ATK:
            begin
                if (atk_sum >= {1'b0, vaa_pkg::ONE_Q16})
                begin
                    res.level = vaa_pkg::ONE_Q16;
                    res.stage = vaa_pkg::STG_DEC;
                end
                else
                begin
                    res.level = atk_sum[16:0];
                end
            end
            vaa_pkg::STG_DEC:
            begin
                res.level = above_reg ? (level_in - delta) : (level_in + delta);
                if ({1'b0, res.level} < ({1'b0, cfg.sus_level} + vaa_pkg::DECAY_EPS))
                begin
                    res.stage = vaa_pkg::STG_SUS;
                end
            end
            vaa_pkg::STG_REL:
            begin
                res.level = level_in - delta;
                if (res.level < vaa_pkg::RELEASE_EPS)
                begin
                    res.level = 17'd0;
                    res.stage = vaa_pkg::STG_IDLE;
                    res.freed = 1'b1;
                end
            end
            default:
            begin
                res.level = level_in;
            end
        endcase
    end

endmodule

/* src/voice_allocator_adsr_unit.sv */
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser: req_type; tdata: note, velocity, release_all
// m_*       out  m_tvalid/m_tready   tdata: voice..released_count; tlast: last
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// note on: take the request, scan each slot in use, then commit
// note off: take the request, scan each slot in use, then report the count
// tick: take the request, then for each slot in use a product step, then an update step
// reset clears every slot to free and idle and loads the default registers
// a busy output register holds the sequencer in place; no request is taken until
// every result of the current one has been handed over to the output register
module voice_allocator_adsr_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // note[6:0], velocity[13:7], release_all[14], zero[15]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // voice[2:0], voice_note[10:3], stage[13:11],
                                   // level[30:14], voice_velocity[37:31],
                                   // released_count[41:38], zero[47:42]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ON_SCAN  = 3'd1;
    localparam logic [2:0] ST_ON_PICK  = 3'd2;
    localparam logic [2:0] ST_OFF_SCAN = 3'd3;
    localparam logic [2:0] ST_OFF_DONE = 3'd4;
    localparam logic [2:0] ST_TK_MUL   = 3'd5;
    localparam logic [2:0] ST_TK_UPD   = 3'd6;

    localparam int VW = vaa_pkg::VOICE_W;
    localparam int CW = vaa_pkg::COUNT_W;

    // slot table
    logic [7:0]  slot_note_reg  [vaa_pkg::MAX_VOICES];
    logic [2:0]  slot_stage_reg [vaa_pkg::MAX_VOICES];
    logic [16:0] slot_level_reg [vaa_pkg::MAX_VOICES];
    logic [6:0]  slot_vel_reg   [vaa_pkg::MAX_VOICES];
    logic [31:0] slot_age_reg   [vaa_pkg::MAX_VOICES];
    logic [7:0]  slot_note_next;
    logic [2:0]  slot_stage_next;
    logic [16:0] slot_level_next;
    logic [6:0]  slot_vel_next;
    logic [31:0] slot_age_next;
    logic        slot_wr;

    // sequencer
    logic [2:0]    state_reg, state_next;
    logic [VW-1:0] ptr_reg, ptr_next;
    logic [6:0]    note_in_reg, note_in_next;
    logic [6:0]    vel_in_reg, vel_in_next;
    logic          all_in_reg, all_in_next;
    logic          hit_found_reg, hit_found_next;
    logic [VW-1:0] hit_reg, hit_next;
    logic          free_found_reg, free_found_next;
    logic [VW-1:0] free_reg, free_next;
    logic [VW-1:0] old_reg, old_next;
    logic [31:0]   old_age_reg, old_age_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   age_clock_reg, age_clock_next;

    // registers written over the configuration port
    logic [3:0]  cfg_voices_reg;
    logic [16:0] cfg_attack_reg;
    logic [15:0] cfg_decay_reg;
    logic [16:0] cfg_sustain_reg;
    logic [15:0] cfg_release_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;
    logic        out_free;

    // current slot, all reads go through the one pointer
    logic [7:0]    note_rd;
    logic [2:0]    stage_rd;
    logic [16:0]   level_rd;
    logic [6:0]    vel_rd;
    logic [31:0]   age_rd;
    logic          held;
    logic          note_match;
    logic [CW-1:0] n_use;
    logic [VW-1:0] n_last;
    logic          scan_last;
    logic          s_take;
    logic          mul_load;

    vaa_pkg::env_cfg_t env_cfg;
    vaa_pkg::env_res_t env_res;

    assign note_rd  = slot_note_reg[ptr_reg];
    assign stage_rd = slot_stage_reg[ptr_reg];
    assign level_rd = slot_level_reg[ptr_reg];
    assign vel_rd   = slot_vel_reg[ptr_reg];
    assign age_rd   = slot_age_reg[ptr_reg];

    assign held = (stage_rd == vaa_pkg::STG_ATK) || (stage_rd == vaa_pkg::STG_DEC) ||
                  (stage_rd == vaa_pkg::STG_SUS);
    assign note_match = (note_rd == {1'b0, note_in_reg});

    // voice count clamped to 1..MAX_VOICES
    always_comb
    begin
        if (cfg_voices_reg == 4'd0)
        begin
            n_use = CW'(1);
        end
        else if (32'(cfg_voices_reg) > vaa_pkg::MAX_VOICES)
        begin
            n_use = CW'(vaa_pkg::MAX_VOICES);
        end
        else
        begin
            n_use = CW'(cfg_voices_reg);
        end
    end

    assign n_last    = VW'(n_use - CW'(1));
    assign scan_last = (ptr_reg == n_last);

    assign env_cfg.atk_step  = cfg_attack_reg;
    assign env_cfg.dec_coef  = cfg_decay_reg;
    assign env_cfg.sus_level = (cfg_sustain_reg > vaa_pkg::ONE_Q16) ? vaa_pkg::ONE_Q16
                                                                    : cfg_sustain_reg;
    assign env_cfg.rel_coef  = cfg_release_reg;

    // shared multiplier and envelope update
    vaa_env_unit u_env
    (
        .clk      (clk),
        .mul_load (mul_load),
        .cfg      (env_cfg),
        .stage_in (stage_rd),
        .level_in (level_rd),
        .res      (env_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_take    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        note_in_next    = note_in_reg;
        vel_in_next     = vel_in_reg;
        all_in_next     = all_in_reg;
        hit_found_next  = hit_found_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        old_next        = old_reg;
        old_age_next    = old_age_reg;
        cnt_next        = cnt_reg;
        age_clock_next  = age_clock_reg;
        slot_wr         = 1'b0;
        slot_note_next  = note_rd;
        slot_stage_next = stage_rd;
        slot_level_next = level_rd;
        slot_vel_next   = vel_rd;
        slot_age_next   = age_rd;
        mul_load        = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_take)
                begin
                    note_in_next    = s_tdata[6:0];
                    vel_in_next     = s_tdata[13:7];
                    all_in_next     = s_tdata[14];
                    ptr_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    unique case (s_tuser)
                        vaa_pkg::REQ_ON:   state_next = ST_ON_SCAN;
                        vaa_pkg::REQ_OFF:  state_next = ST_OFF_SCAN;
                        vaa_pkg::REQ_TICK: state_next = ST_TK_MUL;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ON_SCAN:
            begin
                // first held slot with this note, first idle slot, oldest slot
                if (!hit_found_reg && held && note_match)
                begin
                    hit_found_next = 1'b1;
                    hit_next       = ptr_reg;
                end
                if (!free_found_reg && (stage_rd == vaa_pkg::STG_IDLE))
                begin
                    free_found_next = 1'b1;
                    free_next       = ptr_reg;
                end
                if ((ptr_reg == '0) || (age_rd < old_age_reg))
                begin
                    old_next     = ptr_reg;
                    old_age_next = age_rd;
                end
                if (scan_last)
                begin
                    state_next = ST_ON_PICK;
                    if (hit_found_next)
                    begin
                        ptr_next = hit_next;
                    end
                    else if (free_found_next)
                    begin
                        ptr_next = free_next;
                    end
                    else
                    begin
                        ptr_next = old_next;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + VW'(1);
                end
            end
            ST_ON_PICK:
            begin
                if (out_free)
                begin
                    age_clock_next  = age_clock_reg + 32'd1;
                    slot_wr         = 1'b1;
                    slot_note_next  = {1'b0, note_in_reg};
                    slot_vel_next   = vel_in_reg;
                    slot_stage_next = vaa_pkg::STG_ATK;
                    slot_age_next   = age_clock_next;
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    m_data_next     = {6'd0, 4'd0, vel_in_reg, level_rd, vaa_pkg::STG_ATK,
                                       1'b0, note_in_reg, 3'(ptr_reg)};
                    state_next      = ST_IDLE;
                end
            end
            ST_OFF_SCAN:
            begin
                if (held && (all_in_reg || note_match))
                begin
                    slot_wr         = 1'b1;
                    slot_stage_next = vaa_pkg::STG_REL;
                    cnt_next        = cnt_reg + CW'(1);
                end
                if (scan_last)
                begin
                    state_next = ST_OFF_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + VW'(1);
                end
            end
            ST_OFF_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_data_next  = {6'd0, 4'(cnt_reg), 38'd0};
                    state_next   = ST_IDLE;
                end
            end
            ST_TK_MUL:
            begin
                mul_load   = 1'b1;
                state_next = ST_TK_UPD;
            end
            ST_TK_UPD:
            begin
                if (out_free)
                begin
                    slot_wr         = 1'b1;
                    slot_level_next = env_res.level;
                    slot_stage_next = env_res.stage;
                    if (env_res.freed)
                    begin
                        slot_note_next = vaa_pkg::NOTE_FREE;
                    end
                    m_valid_next = 1'b1;
                    m_last_next  = scan_last;
                    m_data_next  = {6'd0, 4'd0, vel_rd, slot_level_next, slot_stage_next,
                                    slot_note_next, 3'(ptr_reg)};
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + VW'(1);
                        state_next = ST_TK_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            age_clock_reg <= 32'd0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            age_clock_reg <= age_clock_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // request fields, scan trackers and output payload
    always_ff @(posedge clk)
    begin
        note_in_reg    <= note_in_next;
        vel_in_reg     <= vel_in_next;
        all_in_reg     <= all_in_next;
        hit_found_reg  <= hit_found_next;
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        old_reg        <= old_next;
        old_age_reg    <= old_age_next;
        cnt_reg        <= cnt_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    // slot table, at most one entry written per cycle, at the pointer, when slot_wr is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vaa_pkg::MAX_VOICES; i++)
            begin
                slot_note_reg[i]  <= vaa_pkg::NOTE_FREE;
                slot_stage_reg[i] <= vaa_pkg::STG_IDLE;
                slot_level_reg[i] <= 17'd0;
                slot_vel_reg[i]   <= 7'd0;
                slot_age_reg[i]   <= 32'd0;
            end
        end
        else if (slot_wr)
        begin
            slot_note_reg[ptr_reg]  <= slot_note_next;
            slot_stage_reg[ptr_reg] <= slot_stage_next;
            slot_level_reg[ptr_reg] <= slot_level_next;
            slot_vel_reg[ptr_reg]   <= slot_vel_next;
            slot_age_reg[ptr_reg]   <= slot_age_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_voices_reg  <= 4'd8;
            cfg_attack_reg  <= 17'd655;
            cfg_decay_reg   <= 16'd655;
            cfg_sustain_reg <= 17'd52429;
            cfg_release_reg <= 16'd655;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vaa_pkg::REG_VOICES:  cfg_voices_reg  <= cfg_data[3:0];
                vaa_pkg::REG_ATTACK:  cfg_attack_reg  <= cfg_data;
                vaa_pkg::REG_DECAY:   cfg_decay_reg   <= cfg_data[15:0];
                vaa_pkg::REG_SUSTAIN: cfg_sustain_reg <= cfg_data;
                vaa_pkg::REG_RELEASE: cfg_release_reg <= cfg_data[15:0];
                default:
                begin
                    cfg_voices_reg <= cfg_voices_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // back at rest, a result still waiting must be the final one of its request
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && m_valid_reg |-> m_last_reg)
        else $error("non-final result pending while sequencer idle");

    // a free slot never keeps a note
    a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_rd == vaa_pkg::STG_IDLE) |-> (note_rd == vaa_pkg::NOTE_FREE))
        else $error("idle slot still holds a note");

    // envelope never goes above one
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level_rd <= vaa_pkg::ONE_Q16)
        else $error("envelope level above one");

    // every product load is followed by the update step, which may then wait for the output register
    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        mul_load |=> (state_reg == ST_TK_UPD))
        else $error("product loaded without an update step");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    // quiet cycles allowed before the run is declared stuck; the long output
    // hold-off (HOLD_CYCLES) and the slowest random stall are far below this
    localparam int WATCHDOG_LIMIT = 4000;
    // settling wait after the last owed report; a tick over eight slots needs a product and an update step per slot
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 300;
    // request kind the block drops without a result
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]  voice;
        logic [7:0]  note;
        logic [2:0]  stage;
        logic [16:0] level;
        logic [6:0]  velocity;
        logic [3:0]  released;
        logic        last;
    } voice_report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // note[6:0], velocity[13:7], release_all[14], zero[15]
    logic [1:0]  s_tuser;    // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // voice, voice_note, stage, level, voice_velocity, released_count
    logic        m_tlast;    // last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    voice_allocator_adsr_unit dut (.*);

    // predictor copy of the voice table
    logic [7:0]  held_note     [vaa_pkg::MAX_VOICES];
    logic [2:0]  env_stage     [vaa_pkg::MAX_VOICES];
    logic [16:0] env_level     [vaa_pkg::MAX_VOICES];
    logic [6:0]  held_velocity [vaa_pkg::MAX_VOICES];
    logic [31:0] note_age      [vaa_pkg::MAX_VOICES];
    logic [31:0] age_stamp;

    // predictor copy of the registers
    logic [3:0]  voices_reg;
    logic [16:0] attack_reg;
    logic [15:0] decay_reg;
    logic [16:0] sustain_reg;
    logic [15:0] release_reg;

    voice_report_t voice_reports[$];   // reports still owed by the block

    int          mismatches;
    int          quiet_cycles;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          hold_left;
    bit          hold_req;
    logic [6:0]  note_pool [6];

    // ---------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void reset_voice_table();
        for (int i = 0; i < vaa_pkg::MAX_VOICES; i++)
        begin
            held_note[i]     = vaa_pkg::NOTE_FREE;
            env_stage[i]     = vaa_pkg::STG_IDLE;
            env_level[i]     = '0;
            held_velocity[i] = '0;
            note_age[i]      = '0;
        end
        age_stamp   = '0;
        voices_reg  = 4'd8;
        attack_reg  = 17'd655;
        decay_reg   = 16'd655;
        sustain_reg = 17'd52429;
        release_reg = 16'd655;
    endfunction

    // zero acts as mono, anything past the table as the full table
    function automatic int unsigned slots_in_use();
        if (voices_reg == 0)
            return 1;
        if (voices_reg > vaa_pkg::MAX_VOICES)
            return vaa_pkg::MAX_VOICES;
        return voices_reg;
    endfunction

    function automatic bit is_held(logic [2:0] stg);
        return stg == vaa_pkg::STG_ATK || stg == vaa_pkg::STG_DEC || stg == vaa_pkg::STG_SUS;
    endfunction

    // mag * coef / 65536, rounded up so a nonzero coefficient on a nonzero mag always moves
    function automatic logic [31:0] frac_up(logic [31:0] mag, logic [15:0] coef);
        logic [47:0] prod;
        prod = mag * coef;
        return 32'((prod + 48'd65535) >> 16);
    endfunction

    // same note still held, else lowest idle slot, else oldest (lowest index on a tie)
    function automatic int unsigned pick_slot(int unsigned n, logic [6:0] note);
        int unsigned best;
        int unsigned i;
        best = 0;
        if (n == 1)
            return 0;
        for (i = 0; i < n; i++)
            if (held_note[i] == {1'b0, note} && is_held(env_stage[i]))
                return i;
        for (i = 0; i < n; i++)
            if (env_stage[i] == vaa_pkg::STG_IDLE)
                return i;
        for (i = 1; i < n; i++)
            if (note_age[i] < note_age[best])
                best = i;
        return best;
    endfunction

    function automatic void advance_envelope(int unsigned i);
        logic [31:0] sus;
        logic [31:0] lv;
        int          gap;
        sus = (sustain_reg > vaa_pkg::ONE_Q16) ? 32'(vaa_pkg::ONE_Q16) : 32'(sustain_reg);
        lv  = 32'(env_level[i]);
        case (env_stage[i])
            vaa_pkg::STG_ATK:
            begin
                lv = lv + attack_reg;
                if (lv >= vaa_pkg::ONE_Q16)
                begin
                    lv           = 32'(vaa_pkg::ONE_Q16);
                    env_stage[i] = vaa_pkg::STG_DEC;
                end
            end
            vaa_pkg::STG_DEC:
            begin
                if (lv >= sus)
                    lv = lv - frac_up(lv - sus, decay_reg);
                else
                    lv = lv + frac_up(sus - lv, decay_reg);
                gap = int'(lv) - int'(sus);
                if (gap < int'(vaa_pkg::DECAY_EPS))
                    env_stage[i] = vaa_pkg::STG_SUS;
            end
            vaa_pkg::STG_REL:
            begin
                lv = lv - frac_up(lv, release_reg);
                if (lv < vaa_pkg::RELEASE_EPS)
                begin
                    lv           = '0;
                    env_stage[i] = vaa_pkg::STG_IDLE;
                    held_note[i] = vaa_pkg::NOTE_FREE;
                end
            end
            default: ;
        endcase
        env_level[i] = lv[16:0];
    endfunction

    function automatic voice_report_t slot_report(int unsigned i, logic last);
        voice_report_t r;
        r.voice    = 3'(i);
        r.note     = held_note[i];
        r.stage    = env_stage[i];
        r.level    = env_level[i];
        r.velocity = held_velocity[i];
        r.released = '0;
        r.last     = last;
        return r;
    endfunction

    // work out the reports for one accepted request and queue them
    function automatic void predict_request(logic [1:0] kind, logic [6:0] note,
                                            logic [6:0] vel, logic all);
        int unsigned   n;
        int unsigned   v;
        int unsigned   cnt;
        voice_report_t r;
        n = slots_in_use();
        case (kind)
            vaa_pkg::REQ_ON:
            begin
                v                = pick_slot(n, note);
                held_note[v]     = {1'b0, note};
                held_velocity[v] = vel;
                env_stage[v]     = vaa_pkg::STG_ATK;
                age_stamp        = age_stamp + 1;
                note_age[v]      = age_stamp;
                voice_reports.push_back(slot_report(v, 1'b1));
            end
            vaa_pkg::REQ_OFF:
            begin
                cnt = 0;
                for (int unsigned i = 0; i < n; i++)
                    if (is_held(env_stage[i]) && (all || held_note[i] == {1'b0, note}))
                    begin
                        env_stage[i] = vaa_pkg::STG_REL;
                        cnt++;
                    end
                r          = '0;
                r.released = 4'(cnt);
                r.last     = 1'b1;
                voice_reports.push_back(r);
            end
            vaa_pkg::REQ_TICK:
            begin
                for (int unsigned i = 0; i < n; i++)
                begin
                    advance_envelope(i);
                    voice_reports.push_back(slot_report(i, i + 1 == n));
                end
            end
            default: ;   // dropped by the block
        endcase
    endfunction

    function automatic void store_register(logic [2:0] idx, logic [16:0] data);
        case (idx)
            vaa_pkg::REG_VOICES:  voices_reg  = data[3:0];
            vaa_pkg::REG_ATTACK:  attack_reg  = data;
            vaa_pkg::REG_DECAY:   decay_reg   = data[15:0];
            vaa_pkg::REG_SUSTAIN: sustain_reg = data;
            vaa_pkg::REG_RELEASE: release_reg = data[15:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // monitor and checker: requests and register writes feed the predictor,
    // results are compared with the oldest owed report
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        voice_report_t got;
        voice_report_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                store_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[6:0], s_tdata[13:7], s_tdata[14]);
            if (m_tvalid && m_tready)
            begin
                got.voice    = m_tdata[2:0];
                got.note     = m_tdata[10:3];
                got.stage    = m_tdata[13:11];
                got.level    = m_tdata[30:14];
                got.velocity = m_tdata[37:31];
                got.released = m_tdata[41:38];
                got.last     = m_tlast;
                if (voice_reports.size() == 0)
                begin
                    $error("result with nothing owed: voice %0d stage %0d level %0d",
                           got.voice, got.stage, got.level);
                    mismatches++;
                end
                else
                begin
                    want = voice_reports.pop_front();
                    check_field("voice", want.voice, got.voice);
                    check_field("voice_note", want.note, got.note);
                    check_field("stage", want.stage, got.stage);
                    check_field("level", want.level, got.level);
                    check_field("voice_velocity", want.velocity, got.velocity);
                    check_field("released_count", want.released, got.released);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    // watchdog: no handshake of any kind for too long means the block is stuck
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("voice_allocator_adsr_unit: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stalls, or a long hold-off counted here when asked for
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    // valid is left high on return so back-to-back requests with no send gap never toggle it
    task automatic send_request(logic [1:0] kind, logic [6:0] note, logic [6:0] vel,
                                logic all);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, all, vel, note};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait until every owed report is in, then let a dropped request finish too
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (voice_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [16:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers only change with the block idle
    task automatic load_envelope_setup(logic [3:0] voices, logic [16:0] atk, logic [15:0] dec,
                                       logic [16:0] sus, logic [15:0] rel);
        wait_for_drain();
        write_register(vaa_pkg::REG_VOICES, 17'(voices));
        write_register(vaa_pkg::REG_ATTACK, atk);
        write_register(vaa_pkg::REG_DECAY, 17'(dec));
        write_register(vaa_pkg::REG_SUSTAIN, sus);
        write_register(vaa_pkg::REG_RELEASE, 17'(rel));
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // allocation at the reset settings: extremes of note and velocity, retrigger
    // of a held note, a note off that matches nothing, stealing the oldest voice,
    // release of one note and of all, a dropped request kind
    task automatic test_note_allocation();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_ON, 7'd0, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_ON, 7'd127, 7'd127, 1'b0);
        send_request(vaa_pkg::REQ_ON, 7'd0, 7'd100, 1'b0);      // retrigger, same slot
        send_request(vaa_pkg::REQ_OFF, 7'd5, 7'd0, 1'b0);       // nothing released
        for (int k = 10; k < 16; k++)
            send_request(vaa_pkg::REQ_ON, 7'(k), 7'(k * 7), 1'b0);
        send_request(vaa_pkg::REQ_ON, 7'd64, 7'd33, 1'b0);      // table full, steal oldest
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_OFF, 7'd0, 7'd0, 1'b0);
        send_request(REQ_NONE, 7'h7F, 7'h7F, 1'b1);
        send_request(vaa_pkg::REQ_OFF, 7'd99, 7'd0, 1'b1);      // release everything held
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);
    endtask

    // envelope extremes: full-scale steps, sustain past one, zero coefficients,
    // mono and out-of-range voice counts
    task automatic test_envelope_limits();
        load_envelope_setup(4'd1, 17'd65536, 16'd65535, 17'd131071, 16'd65535);
        send_request(vaa_pkg::REQ_ON, 7'd60, 7'd90, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // straight to full scale
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // already at sustain
        send_request(vaa_pkg::REQ_ON, 7'd61, 7'd12, 1'b0);      // mono keeps slot 0 and level
        send_request(vaa_pkg::REQ_OFF, 7'd61, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // drops under threshold at once
        load_envelope_setup(4'd0, 17'd131071, 16'd0, 17'd0, 16'd0);
        send_request(vaa_pkg::REQ_ON, 7'd85, 7'd42, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // decay frozen
        send_request(vaa_pkg::REQ_OFF, 7'd85, 7'd0, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // release frozen
        load_envelope_setup(4'd15, 17'd0, 16'd32768, 17'd65536, 16'd40000);
        send_request(vaa_pkg::REQ_ON, 7'd42, 7'd85, 1'b0);
        send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);      // attack frozen
        send_request(vaa_pkg::REQ_OFF, 7'd0, 7'd0, 1'b1);
    endtask

    // mostly well-formed play from a small note pool so note offs find their
    // notes and envelopes run through every stage, with some stray requests
    task automatic test_random_traffic(int gap_pct, int stall_pct, int items);
        int          sent;
        int unsigned roll;
        logic [1:0]  kind;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic        all;
        load_envelope_setup(($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                     : 4'($urandom_range(8, 2)),
                            17'($urandom_range(70000, 2000)),
                            16'($urandom_range(65535, 3000)),
                            17'($urandom_range(70000, 0)),
                            16'($urandom_range(65535, 15000)));
        for (int k = 0; k < 6; k++)
            note_pool[k] = 7'($urandom_range(127));
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(99);
            note = ($urandom_range(4) == 0) ? 7'($urandom_range(127))
                                            : note_pool[$urandom_range(5)];
            vel  = 7'($urandom_range(127));
            all  = 1'($urandom_range(1));
            if (roll < 45)
                kind = vaa_pkg::REQ_TICK;
            else if (roll < 75)
                kind = vaa_pkg::REQ_ON;
            else if (roll < 95)
            begin
                kind = vaa_pkg::REQ_OFF;
                all  = ($urandom_range(6) == 0);
            end
            else
                kind = REQ_NONE;
            send_request(kind, note, vel, all);
            if (kind != REQ_NONE)
                sent++;
        end
    endtask

    // the receiver holds off for a long stretch while requests keep coming,
    // so the output register stays full and the input stalls
    task automatic test_output_backpressure();
        load_envelope_setup(4'd8, 17'd3000, 16'd20000, 17'd40000, 16'd30000);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (int k = 0; k < 30; k++)
        begin
            if (k % 3 == 0)
                send_request(vaa_pkg::REQ_ON, 7'($urandom_range(127)),
                             7'($urandom_range(127)), 1'b0);
            else
                send_request(vaa_pkg::REQ_TICK, 7'd0, 7'd0, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = vaa_pkg::REQ_ON;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = vaa_pkg::REG_VOICES;
        cfg_data       = '0;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        hold_req       = 1'b0;
        reset_voice_table();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_note_allocation();
        test_envelope_limits();
        test_random_traffic(0, 0, 75);       // no idling
        test_random_traffic(80, 0, 75);      // sender mostly idle
        test_random_traffic(0, 80, 75);      // receiver mostly stalling
        test_random_traffic(6, 6, 75);       // light idling on both sides
        test_output_backpressure();
        wait_for_drain();

        if (mismatches == 0)
            $display("voice_allocator_adsr_unit: match");
        else
            $display("voice_allocator_adsr_unit: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/vaa_pkg.sv
src/vaa_env_unit.sv
src/voice_allocator_adsr_unit.sv
tb/sv/tb_top.sv
